// ===== rtl/rtcb_pkg.sv =====
// Package: shared constants, mode codes and level scaling for the RSSI capture buffer.
`timescale 1ns / 1ps
package rtcb_pkg;

  // Ring geometry
  localparam int unsigned RING_DEPTH  = 1024;
  localparam int unsigned ADDR_W      = $clog2(RING_DEPTH);
  localparam int unsigned WINDOW_LEN  = 128;
  localparam int unsigned PRE_TRIGGER = 32;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned COLUMN_W = 7;
  localparam int unsigned LEVEL_W  = 7;

  // Sample limits in whole dBm
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN    = -8'sd127;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX    = 8'sd0;
  localparam logic signed [SAMPLE_W-1:0] DBM_FLOOR     = -8'sd100;
  localparam logic signed [SAMPLE_W-1:0] DBM_CEIL      = -8'sd30;
  localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RST = -8'sd72;

  // x*127/70 done as (x*127*14980) >> 20, exact for x*127 below 43690
  localparam logic [14:0] LEVEL_RECIP = 15'd14980;
  localparam int unsigned LEVEL_SHIFT = 20;

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_FRAME  = 2'd1,
    MODE_COLUMN = 2'd2
  } mode_e;

  localparam logic KIND_FRAME  = 1'b0;
  localparam logic KIND_COLUMN = 1'b1;

  // Clamp to -100..-30 dBm and scale onto 0..127, floored
  function automatic logic [LEVEL_W-1:0] level_of(input logic signed [SAMPLE_W-1:0] v);
    logic signed [SAMPLE_W-1:0] c;
    logic [6:0]  x;
    logic [13:0] p;
    logic [28:0] q;
    c = v;
    if (v < DBM_FLOOR) begin
      c = DBM_FLOOR;
    end else if (v > DBM_CEIL) begin
      c = DBM_CEIL;
    end
    x = 7'(c - DBM_FLOOR);
    p = {x, 7'b0} - {7'b0, x};
    q = 29'(p) * 29'(LEVEL_RECIP);
    return LEVEL_W'(q >> LEVEL_SHIFT);
  endfunction

endpackage

// ===== rtl/rtcb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module rtcb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/rssi_trigger_capture_buffer_top.sv =====
// Top level: RSSI capture ring with rising-edge trigger and scaled window reads.
`timescale 1ns / 1ps
// Usage
//   Requests enter on the s_axis group. tuser carries the mode: store sample,
//   start frame or read window column; the fourth code is dropped silently.
//   Sample stores produce no result. Frame starts answer with result kind 0
//   and the trigger flag; column reads answer with kind 1 and the level,
//   i.e. the stored dBm clamped to -100..-30 and scaled onto 0..127.
//   Results leave on the m_axis group, kind in tuser.
//   cfg_we_i writes the trigger threshold (signed dBm, -72 after reset);
//   write it only while no request is in flight.
// Timing
//   One request per cycle while m_axis_tready holds high. A request is accepted
//   into the read stage, where the sample memory reads at the accepting edge;
//   the result then moves on to the output register, which takes the scaled
//   level once it is free or drains, and is valid on m_axis from there.
// Reset
//   Control state clears at once; there is no clearing pass. The ring fills
//   in order, so a fill mark (write position plus a wrapped flag) tells which
//   entries were never written, and those read as -100 dBm.
// Back-pressure
//   A stalled receiver holds the output register; the read stage behind it
//   keeps its result, and s_axis_tready drops only once both are full.
module rssi_trigger_capture_buffer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,   // threshold_dbm
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] sample_dbm, [14:8] column, [15] zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] mode
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [0] triggered, [7:1] level
  output logic        m_axis_tuser   // [0] result_kind
);

  localparam int unsigned AW = rtcb_pkg::ADDR_W;

  // Configuration
  logic signed [7:0] threshold_q;

  // Ring and trigger state
  logic [AW-1:0] write_pos_q, write_pos_d;
  logic          wrapped_q, wrapped_d;
  logic          armed_q, armed_d;
  logic          edge_pending_q, edge_pending_d;
  logic [AW-1:0] edge_pos_q, edge_pos_d;
  logic [AW-1:0] window_start_q, window_start_d;

  // Read stage and output register
  logic       s1_valid_q, s1_kind_q, s1_trig_q, s1_hit_q;
  logic       out_valid_q, out_kind_q, out_trig_q;
  logic [6:0] out_level_q;

  // Request decode
  logic                    in_acc;
  rtcb_pkg::mode_e         mode;
  logic signed [7:0]       sample_in, sample_sat;
  logic [6:0]              column_in;
  logic                    s1_move;
  logic                    ram_we, ram_re;
  logic [AW-1:0]           rd_addr;
  logic [7:0]              ram_rdata;
  logic signed [7:0]       rd_value;
  logic                    s1_load, s1_trig_d;

  assign mode      = rtcb_pkg::mode_e'(s_axis_tuser);
  assign sample_in = s_axis_tdata[7:0];
  assign column_in = s_axis_tdata[14:8];

  // Advance the read stage whenever the output register is free or drains
  assign s1_move       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_move;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Saturate the sample into -127..0
  always_comb begin
    sample_sat = sample_in;
    if (sample_in < rtcb_pkg::SAMPLE_MIN) begin
      sample_sat = rtcb_pkg::SAMPLE_MIN;
    end else if (sample_in > rtcb_pkg::SAMPLE_MAX) begin
      sample_sat = rtcb_pkg::SAMPLE_MAX;
    end
  end

  assign rd_addr = window_start_q + AW'(column_in);

  always_comb begin
    write_pos_d    = write_pos_q;
    wrapped_d      = wrapped_q;
    armed_d        = armed_q;
    edge_pending_d = edge_pending_q;
    edge_pos_d     = edge_pos_q;
    window_start_d = window_start_q;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    s1_load        = 1'b0;
    s1_trig_d      = 1'b0;
    if (in_acc) begin
      unique case (mode)
        rtcb_pkg::MODE_SAMPLE: begin
          ram_we = 1'b1;
          // Arm below threshold; fire on the first sample back at or above it
          if (sample_sat < threshold_q) begin
            armed_d = 1'b1;
          end else if (armed_q) begin
            armed_d        = 1'b0;
            edge_pending_d = 1'b1;
            edge_pos_d     = write_pos_q;
          end
          write_pos_d = write_pos_q + AW'(1);
          if (write_pos_q == AW'(rtcb_pkg::RING_DEPTH - 1)) begin
            wrapped_d = 1'b1;
          end
        end
        rtcb_pkg::MODE_FRAME: begin
          s1_load   = 1'b1;
          s1_trig_d = edge_pending_q;
          if (edge_pending_q) begin
            window_start_d = edge_pos_q - AW'(rtcb_pkg::PRE_TRIGGER);
            edge_pending_d = 1'b0;
          end else begin
            window_start_d = write_pos_q - AW'(rtcb_pkg::WINDOW_LEN);
          end
        end
        rtcb_pkg::MODE_COLUMN: begin
          s1_load = 1'b1;
          ram_re  = 1'b1;
        end
        default: begin
          // drop the unused code
        end
      endcase
    end
  end

  rtcb_ram #(
    .WIDTH (8),
    .DEPTH (rtcb_pkg::RING_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (write_pos_q),
    .wdata_i (sample_sat),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Entries never written read as the reset floor
  assign rd_value = s1_hit_q ? signed'(ram_rdata) : rtcb_pkg::DBM_FLOOR;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q    <= rtcb_pkg::THRESHOLD_RST;
      write_pos_q    <= '0;
      wrapped_q      <= 1'b0;
      armed_q        <= 1'b0;
      edge_pending_q <= 1'b0;
      edge_pos_q     <= '0;
      window_start_q <= '0;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        threshold_q <= cfg_wdata_i;
      end
      write_pos_q    <= write_pos_d;
      wrapped_q      <= wrapped_d;
      armed_q        <= armed_d;
      edge_pending_q <= edge_pending_d;
      edge_pos_q     <= edge_pos_d;
      window_start_q <= window_start_d;
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_kind_q <= (mode == rtcb_pkg::MODE_COLUMN) ? rtcb_pkg::KIND_COLUMN
                                                   : rtcb_pkg::KIND_FRAME;
      s1_trig_q <= s1_trig_d;
      s1_hit_q  <= wrapped_q || (rd_addr < write_pos_q);
    end
    if (s1_move) begin
      out_kind_q  <= s1_kind_q;
      out_trig_q  <= s1_trig_q;
      out_level_q <= (s1_kind_q == rtcb_pkg::KIND_COLUMN) ? rtcb_pkg::level_of(rd_value)
                                                          : 7'd0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_level_q, out_trig_q};
  assign m_axis_tuser  = out_kind_q;

endmodule
